>>> rtl/three_channel_rank_select_assert.svh
// Assertion macros shared by the rank select checker.
`ifndef THREE_CHANNEL_RANK_SELECT_ASSERT_SVH
`define THREE_CHANNEL_RANK_SELECT_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define TCRS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent at one edge, consequent at the next edge.
`define TCRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tcrs_pkg.sv
// Shared constants and types for the three channel rank select.
`timescale 1ns / 1ps

package tcrs_pkg;

	localparam int SAMPLES_DEF    = 8;
	localparam int VALUE_BITS_DEF = 10;

	localparam int              RANK_W     = 3;
	localparam logic [RANK_W-1:0] RANK_RESET = 3'd4;

	// Commands from the sequencer to each channel lane.
	typedef struct packed {
		logic load;   // start inserting a new word into the sorted store
		logic step;   // one compare and shift step of the insertion
		logic fetch;  // read the store at the selected rank
	} tcrs_ctl_t;

endpackage

>>> rtl/tcrs_lane.sv
// One channel: sorted store with an insertion step unit and a rank read.
`timescale 1ns / 1ps

module tcrs_lane #(
	parameter int SAMPLES    = tcrs_pkg::SAMPLES_DEF,
	parameter int VALUE_BITS = tcrs_pkg::VALUE_BITS_DEF,
	localparam int IDX_W     = $clog2(SAMPLES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tcrs_pkg::tcrs_ctl_t   ctl,
	input  logic [IDX_W-1:0]      slot,
	input  logic [IDX_W-1:0]      rank,
	input  logic [VALUE_BITS-1:0] new_value,
	output logic                  done,
	output logic [VALUE_BITS-1:0] rd_data
);
	import tcrs_pkg::*;

	logic [VALUE_BITS-1:0] mem [SAMPLES];
	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] rd_q;
	logic [IDX_W-1:0]      pos_q;
	logic [IDX_W-1:0]      raddr;
	logic                  done_q;
	logic                  rd_en;
	logic                  move;

	// The entries below the insertion point are already sorted, so the new
	// word walks down from its slot, pushing larger entries up by one place.
	// The read one step ahead keeps one compare per cycle.
	always_comb begin
		rd_en = ctl.load | ctl.step | ctl.fetch;
		priority if (ctl.load) begin
			raddr = (slot == '0) ? '0 : slot - IDX_W'(1);
		end else if (ctl.step) begin
			raddr = (pos_q < IDX_W'(2)) ? '0 : pos_q - IDX_W'(2);
		end else begin
			raddr = rank;
		end
		move = ctl.step && !done_q && (pos_q != '0) && (rd_q > val_q);
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && !done_q) begin
			mem[pos_q] <= move ? rd_q : val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q <= new_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b1;
			pos_q  <= '0;
		end else if (ctl.load) begin
			done_q <= 1'b0;
			pos_q  <= slot;
		end else if (ctl.step && !done_q) begin
			if (move) begin
				pos_q <= pos_q - IDX_W'(1);
			end else begin
				done_q <= 1'b1;
			end
		end
	end

	assign done    = done_q;
	assign rd_data = rd_q;

endmodule

>>> rtl/three_channel_rank_select.sv
// Top level of the three channel rank select.
`timescale 1ns / 1ps

// Collects bursts of SAMPLES readings of three sensor channels and, on the
// last reading of each burst, gives one word holding the value at rank
// pick_rank (0 is the smallest, values above SAMPLES-1 act as SAMPLES-1) of
// each channel; other readings give no output word. Each channel keeps its
// store sorted by insertion, one compare and move per cycle in its own
// lane, and the three lanes run in lockstep. How long a reading in slot k
// of the burst takes is set by how far the slowest lane must walk the new
// value down its store; the last reading of a burst adds the rank read, the
// output load and any wait for the previous output word to be taken.
// in_ready is low from each accept until the block is idle again.
// pick_rank may be written at any time the block is idle.
module three_channel_rank_select #(
	parameter int SAMPLES    = tcrs_pkg::SAMPLES_DEF,
	parameter int VALUE_BITS = tcrs_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tcrs_pkg::RANK_W-1:0] pick_rank,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [VALUE_BITS-1:0]       left_value,
	input  logic [VALUE_BITS-1:0]       center_value,
	input  logic [VALUE_BITS-1:0]       right_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [VALUE_BITS-1:0]       left_ranked,
	output logic [VALUE_BITS-1:0]       center_ranked,
	output logic [VALUE_BITS-1:0]       right_ranked
);
	import tcrs_pkg::*;

	localparam int IDX_W = $clog2(SAMPLES);
	localparam int CMP_W = (RANK_W > IDX_W) ? RANK_W : IDX_W;
	localparam logic [CMP_W-1:0] MAX_RANK = CMP_W'(SAMPLES - 1);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SAMPLES - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_STEP  = 4'b0010,
		ST_FETCH = 4'b0100,
		ST_CAPT  = 4'b1000
	} state_t;

	state_t                state_q;
	logic [RANK_W-1:0]     rank_q;
	logic [IDX_W-1:0]      count_q;
	logic                  last_q;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] left_q;
	logic [VALUE_BITS-1:0] center_q;
	logic [VALUE_BITS-1:0] right_q;

	tcrs_ctl_t             ctl;
	logic                  accept;
	logic                  out_load;
	logic                  all_done;
	logic [CMP_W-1:0]      rank_ext;
	logic [IDX_W-1:0]      rank_sel;
	logic [2:0]            lane_done;
	logic [VALUE_BITS-1:0] left_rd;
	logic [VALUE_BITS-1:0] center_rd;
	logic [VALUE_BITS-1:0] right_rd;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign all_done  = &lane_done;
	assign out_load  = (state_q == ST_CAPT) && (!out_valid_q || out_ready);

	always_comb begin
		rank_ext = CMP_W'(rank_q);
		rank_sel = (rank_ext > MAX_RANK) ? IDX_W'(MAX_RANK) : IDX_W'(rank_ext);
		ctl.load  = accept;
		ctl.step  = (state_q == ST_STEP);
		ctl.fetch = (state_q == ST_FETCH);
	end

	tcrs_lane #(.SAMPLES(SAMPLES), .VALUE_BITS(VALUE_BITS)) u_left (
		.clk, .arst_n, .ctl, .slot(count_q), .rank(rank_sel),
		.new_value(left_value), .done(lane_done[0]), .rd_data(left_rd)
	);

	tcrs_lane #(.SAMPLES(SAMPLES), .VALUE_BITS(VALUE_BITS)) u_center (
		.clk, .arst_n, .ctl, .slot(count_q), .rank(rank_sel),
		.new_value(center_value), .done(lane_done[1]), .rd_data(center_rd)
	);

	tcrs_lane #(.SAMPLES(SAMPLES), .VALUE_BITS(VALUE_BITS)) u_right (
		.clk, .arst_n, .ctl, .slot(count_q), .rank(rank_sel),
		.new_value(right_value), .done(lane_done[2]), .rd_data(right_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= RANK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rank_q <= pick_rank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q  <= (count_q == LAST_SLOT);
						count_q <= (count_q == LAST_SLOT) ? '0 : count_q + IDX_W'(1);
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (all_done) begin
						state_q <= last_q ? ST_FETCH : ST_IDLE;
					end
				end
				ST_FETCH: begin
					state_q <= ST_CAPT;
				end
				ST_CAPT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_q   <= left_rd;
			center_q <= center_rd;
			right_q  <= right_rd;
		end
	end

	assign out_valid     = out_valid_q;
	assign left_ranked   = left_q;
	assign center_ranked = center_q;
	assign right_ranked  = right_q;

endmodule

>>> rtl/tcrs_checker.sv
// Port level checker for the three channel rank select, with its bind.
`timescale 1ns / 1ps

`include "three_channel_rank_select_assert.svh"

module tcrs_checker #(
	parameter int VALUE_BITS = tcrs_pkg::VALUE_BITS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [VALUE_BITS-1:0]       left_ranked,
	input logic [VALUE_BITS-1:0]       center_ranked,
	input logic [VALUE_BITS-1:0]       right_ranked
);
	import tcrs_pkg::*;

	// A word being sorted in always drops in_ready in the cycle after its accept.
	`TCRS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "in_ready high after accept")

	// A new output word is only loaded after the sequencer has been busy.
	`TCRS_ASSERT(a_out_after_busy, $rose(out_valid) |-> !$past(in_ready), "output word without busy cycle")

	// The register port never stalls.
	`TCRS_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "cfg_ready low")

	// A stalled output word stays put.
	`TCRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(left_ranked) && $stable(center_ranked) && $stable(right_ranked), "stalled output word changed")

endmodule

bind three_channel_rank_select tcrs_checker #(.VALUE_BITS(VALUE_BITS)) u_tcrs_checker (.*);
